@@ hdl/lcd_quarter_duty_half_bias_scanner_top_defines.svh @@
// Assertion macros used by the scanner core.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef LCD_QUARTER_DUTY_HALF_BIAS_SCANNER_TOP_DEFINES_SVH
`define LCD_QUARTER_DUTY_HALF_BIAS_SCANNER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define LCDSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every edge, reset included.
`define LCDSC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LCDSC_ASSERT(lbl, prop, msg)
`define LCDSC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/lcdsc_pkg.sv @@
`timescale 1ns / 1ps

package lcdsc_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_DIGIT = 2'd1;
   localparam logic [1:0] KIND_FLAGS = 2'd2;
   localparam logic [1:0] KIND_EXTRA = 2'd3;

   localparam int unsigned DIGITS      = 4;
   localparam int unsigned FRAME_BYTES = 5;
   localparam int unsigned SEG_LINES   = 9;

   // Digit code that shows no segments; larger codes collapse to it.
   localparam logic [4:0] BLANK_CODE = 5'd16;

   localparam logic [7:0] PRESCALE_RESET = 8'd125;

   typedef logic [4:0] digit_code_type;
   typedef logic [7:0] frame_byte_type;

   // One result beat.
   typedef struct packed {
      logic [SEG_LINES-1:0] segment_lines;
      logic [1:0]           com_select;
      logic                 com_level;
      logic                 half_second;
   } rsp_beat_type;

   // Seven-segment pattern for a stored digit code (bit 7 of the frame byte holds the flag).
   function automatic logic [6:0] seg_pattern(input digit_code_type code);
      logic [6:0] pat;
      case (code)
         5'd0:    pat = 7'h7B;
         5'd1:    pat = 7'h30;
         5'd2:    pat = 7'h5D;
         5'd3:    pat = 7'h75;
         5'd4:    pat = 7'h36;
         5'd5:    pat = 7'h67;
         5'd6:    pat = 7'h6F;
         5'd7:    pat = 7'h31;
         5'd8:    pat = 7'h7F;
         5'd9:    pat = 7'h77;
         5'd10:   pat = 7'h3F;
         5'd11:   pat = 7'h6E;
         5'd12:   pat = 7'h4C;
         5'd13:   pat = 7'h7C;
         5'd14:   pat = 7'h4F;
         5'd15:   pat = 7'h0F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

@@ hdl/lcdsc_req_if.sv @@
`timescale 1ns / 1ps

// Request channel: one tick or one store write per beat.
interface lcdsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [1:0] slot;
   logic [7:0] value;

   modport source (output valid, output kind, output slot, output value, input ready);
   modport sink   (input valid, input kind, input slot, input value, output ready);
endinterface

@@ hdl/lcdsc_rsp_if.sv @@
`timescale 1ns / 1ps

// Result channel: one set of drive levels per scan tick.
interface lcdsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] segment_lines;
   logic [1:0] com_select;
   logic       com_level;
   logic       half_second;

   modport source (output valid, output segment_lines, output com_select,
                   output com_level, output half_second, input ready);
   modport sink   (input valid, input segment_lines, input com_select,
                   input com_level, input half_second, output ready);
endinterface

@@ hdl/lcd_quarter_duty_half_bias_scanner_top.sv @@
// A scan tick's result beat is registered and offered in the cycle after acceptance.
// Throughput: one item per cycle while the result register is empty or being taken.
// Store writes give no beat and take effect at the next phase-zero tick.
// Reset (synchronous, active high) clears the stores and scan phase and
// sets the prescaler and its reload register to 125.
`timescale 1ns / 1ps

module lcd_quarter_duty_half_bias_scanner_top (
   input  logic        clock,
   input  logic        reset,
   lcdsc_req_if.sink   req_ch,
   lcdsc_rsp_if.source rsp_ch,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic                    space_ok;
   logic                    res_valid;
   lcdsc_pkg::rsp_beat_type res_beat;

   // Stores, scan and prescaler.
   lcdsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .space_ok  (space_ok),
      .res_valid (res_valid),
      .res_beat  (res_beat)
   );

   // Result register toward the sink.
   lcdsc_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .beat     (res_beat),
      .space_ok (space_ok),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ hdl/lcdsc_core.sv @@
`timescale 1ns / 1ps
`include "lcd_quarter_duty_half_bias_scanner_top_defines.svh"

// Display stores, scan phase and prescaler; forms one result per tick.
module lcdsc_core (
   input  logic                  clock,
   input  logic                  reset,
   lcdsc_req_if.sink             req_ch,
   input  logic                  csr_we,
   input  logic [7:0]            csr_wdata,
   input  logic                  space_ok,
   output logic                  res_valid,
   output lcdsc_pkg::rsp_beat_type res_beat
);

   lcdsc_pkg::digit_code_type digit_ff [lcdsc_pkg::DIGITS];
   lcdsc_pkg::digit_code_type digit_in [lcdsc_pkg::DIGITS];
   lcdsc_pkg::frame_byte_type frame_ff [lcdsc_pkg::FRAME_BYTES];
   lcdsc_pkg::frame_byte_type frame_in [lcdsc_pkg::FRAME_BYTES];
   lcdsc_pkg::frame_byte_type built    [lcdsc_pkg::FRAME_BYTES];
   lcdsc_pkg::frame_byte_type cur      [lcdsc_pkg::FRAME_BYTES];
   logic [3:0] flags_ff, flags_in;
   logic [7:0] extra_ff, extra_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] prescale_ff, prescale_in;
   logic [7:0] ticks_ff, ticks_in;
   logic       accept;
   logic       tick;
   logic [1:0] lo;
   logic [2:0] hi;
   logic [7:0] count_dec;
   logic       pulse;
   logic [lcdsc_pkg::SEG_LINES-1:0] segs;
   lcdsc_pkg::digit_code_type       wr_code;

   assign req_ch.ready = space_ok;
   assign accept       = req_ch.valid && space_ok;
   assign tick         = accept && (req_ch.kind == lcdsc_pkg::KIND_TICK);

   // Clamp digit codes to the blank code.
   assign wr_code = (req_ch.value >= {3'd0, lcdsc_pkg::BLANK_CODE}) ?
                    lcdsc_pkg::BLANK_CODE : req_ch.value[4:0];

   // Frame as it would be loaded at phase zero.
   always_comb begin
      for (int i = 0; i < lcdsc_pkg::DIGITS; i++) begin
         built[i] = {flags_ff[i], lcdsc_pkg::seg_pattern(digit_ff[i])};
      end
      built[lcdsc_pkg::DIGITS] = extra_ff;
      for (int i = 0; i < lcdsc_pkg::FRAME_BYTES; i++) begin
         cur[i] = (phase_ff == 3'd0) ? built[i] : frame_ff[i];
      end
   end

   // Segment line selection for the current phase.
   assign lo = phase_ff[2:1];
   assign hi = {1'b1, lo};
   always_comb begin
      for (int i = 0; i < lcdsc_pkg::DIGITS; i++) begin
         segs[2*i]   = cur[i][{1'b0, lo}];
         segs[2*i+1] = cur[i][hi];
      end
      segs[lcdsc_pkg::SEG_LINES-1] = cur[lcdsc_pkg::DIGITS][{1'b0, lo}];
   end

   // Prescaler decrement and reload.
   assign count_dec = prescale_ff - 8'd1;
   assign pulse     = (count_dec == 8'd0);

   assign res_valid              = tick;
   assign res_beat.segment_lines = phase_ff[0] ? ~segs : segs;
   assign res_beat.com_select    = lo;
   assign res_beat.com_level     = phase_ff[0];
   assign res_beat.half_second   = pulse;

   // Next state of the stores, scan phase, prescaler and reload register.
   always_comb begin
      digit_in    = digit_ff;
      frame_in    = frame_ff;
      flags_in    = flags_ff;
      extra_in    = extra_ff;
      phase_in    = phase_ff;
      prescale_in = prescale_ff;
      ticks_in    = csr_we ? csr_wdata : ticks_ff;
      if (accept) begin
         case (req_ch.kind)
            lcdsc_pkg::KIND_TICK: begin
               if (phase_ff == 3'd0) begin
                  frame_in = built;
               end
               phase_in    = phase_ff + 3'd1;
               prescale_in = pulse ? ticks_ff : count_dec;
            end
            lcdsc_pkg::KIND_DIGIT: begin
               digit_in[req_ch.slot] = wr_code;
            end
            lcdsc_pkg::KIND_FLAGS: begin
               flags_in = req_ch.value[3:0];
            end
            lcdsc_pkg::KIND_EXTRA: begin
               extra_in = req_ch.value;
            end
            default: begin
               extra_in = extra_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lcdsc_pkg::DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
         for (int i = 0; i < lcdsc_pkg::FRAME_BYTES; i++) begin
            frame_ff[i] <= '0;
         end
         flags_ff    <= '0;
         extra_ff    <= '0;
         phase_ff    <= '0;
         prescale_ff <= lcdsc_pkg::PRESCALE_RESET;
         ticks_ff    <= lcdsc_pkg::PRESCALE_RESET;
      end else begin
         digit_ff    <= digit_in;
         frame_ff    <= frame_in;
         flags_ff    <= flags_in;
         extra_ff    <= extra_in;
         phase_ff    <= phase_in;
         prescale_ff <= prescale_in;
         ticks_ff    <= ticks_in;
      end
   end

   // A tick moves the scan forward by exactly one phase.
   `LCDSC_ASSERT(a_phase_step, tick |=> (phase_ff == $past(phase_ff) + 3'd1), "phase did not step")
   // Store writes leave scan and prescaler alone.
   `LCDSC_ASSERT(a_write_holds_scan, (accept && !tick) |=> ($stable(phase_ff) && $stable(prescale_ff)), "write disturbed scan")
   // A half-second pulse reloads the prescaler from the register.
   `LCDSC_ASSERT(a_pulse_reload, (tick && pulse) |=> (prescale_ff == $past(ticks_ff)), "prescaler not reloaded")
   // Stored digit codes never exceed the blank code.
   `LCDSC_ASSERT(a_digit_clamp, (digit_ff[0] <= lcdsc_pkg::BLANK_CODE) && (digit_ff[1] <= lcdsc_pkg::BLANK_CODE) && (digit_ff[2] <= lcdsc_pkg::BLANK_CODE) && (digit_ff[3] <= lcdsc_pkg::BLANK_CODE), "digit code out of range")
   // Reset restores phase zero and the default prescale.
   `LCDSC_ASSERT_ALWAYS(a_reset_state, reset |=> ((phase_ff == 3'd0) && (prescale_ff == lcdsc_pkg::PRESCALE_RESET)), "reset state wrong")

endmodule

@@ hdl/lcdsc_out_reg.sv @@
`timescale 1ns / 1ps

// Result register: holds one beat until the sink takes it.
module lcdsc_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lcdsc_pkg::rsp_beat_type beat,
   output logic                    space_ok,
   lcdsc_rsp_if.source             rsp_ch
);

   logic                    valid_ff, valid_in;
   lcdsc_pkg::rsp_beat_type beat_ff, beat_in;

   // Room for a new beat when empty or when the held beat leaves now.
   assign space_ok = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ch.ready;
      beat_in  = beat_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.segment_lines = beat_ff.segment_lines;
   assign rsp_ch.com_select    = beat_ff.com_select;
   assign rsp_ch.com_level     = beat_ff.com_level;
   assign rsp_ch.half_second   = beat_ff.half_second;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned PHASE_ITEMS    = 250;

   // Tracks the expected drive levels of the scanner and checks each result beat.
   class scan_scoreboard;
      logic [6:0]     glyph_rom [0:16] = '{7'h7B, 7'h30, 7'h5D, 7'h75, 7'h36, 7'h67,
                                           7'h6F, 7'h31, 7'h7F, 7'h77, 7'h3F, 7'h6E,
                                           7'h4C, 7'h7C, 7'h4F, 7'h0F, 7'h00};
      logic [7:0]                reload_ticks;
      lcdsc_pkg::digit_code_type digits [lcdsc_pkg::DIGITS];
      logic [3:0]                flag_mask;
      lcdsc_pkg::frame_byte_type extra_reg;
      lcdsc_pkg::frame_byte_type frame_bytes [lcdsc_pkg::FRAME_BYTES];
      logic [2:0]                phase;
      logic [7:0]                prescale;
      lcdsc_pkg::rsp_beat_type   pending_beats [$];
      int unsigned               errors;
      int unsigned               beats_checked;
      int unsigned               pulses_seen;

      function new();
         reload_ticks = lcdsc_pkg::PRESCALE_RESET;
         prescale     = lcdsc_pkg::PRESCALE_RESET;
         foreach (digits[i]) digits[i] = '0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
         flag_mask     = '0;
         extra_reg     = '0;
         phase         = '0;
         errors        = 0;
         beats_checked = 0;
         pulses_seen   = 0;
      endfunction

      function void set_reload(logic [7:0] ticks);
         reload_ticks = ticks;
      endfunction

      function int unsigned outstanding();
         return pending_beats.size();
      endfunction

      // Applies one accepted request beat; a tick queues the drive levels it produces.
      function void note_request(logic [1:0] kind, logic [1:0] slot, logic [7:0] value);
         logic [1:0]              lo;
         logic [2:0]              hi;
         lcdsc_pkg::rsp_beat_type beat;
         case (kind)
            lcdsc_pkg::KIND_DIGIT: begin
               digits[slot] = (value >= lcdsc_pkg::BLANK_CODE) ?
                              lcdsc_pkg::BLANK_CODE : value[4:0];
            end
            lcdsc_pkg::KIND_FLAGS: begin
               flag_mask = value[3:0];
            end
            lcdsc_pkg::KIND_EXTRA: begin
               extra_reg = value;
            end
            default: begin
               // Phase zero latches a fresh frame from the stores.
               if (phase == 3'd0) begin
                  for (int i = 0; i < lcdsc_pkg::DIGITS; i++)
                     frame_bytes[i] = {flag_mask[i], glyph_rom[digits[i]]};
                  frame_bytes[lcdsc_pkg::FRAME_BYTES-1] = extra_reg;
               end
               lo = phase[2:1];
               hi = {1'b1, lo};
               beat.segment_lines = '0;
               for (int i = 0; i < lcdsc_pkg::DIGITS; i++) begin
                  beat.segment_lines[2*i]   = frame_bytes[i][lo];
                  beat.segment_lines[2*i+1] = frame_bytes[i][hi];
               end
               beat.segment_lines[lcdsc_pkg::SEG_LINES-1] =
                  frame_bytes[lcdsc_pkg::FRAME_BYTES-1][lo];
               // Odd phases drive the inverse levels.
               if (phase[0]) beat.segment_lines = ~beat.segment_lines;
               beat.com_select = lo;
               beat.com_level  = phase[0];
               prescale = prescale - 8'd1;
               beat.half_second = (prescale == 8'd0);
               if (beat.half_second) begin
                  prescale = reload_ticks;
                  pulses_seen++;
               end
               phase = phase + 3'd1;
               pending_beats.push_back(beat);
            end
         endcase
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
         end
      endfunction

      // Compares one result beat with the oldest expected one.
      function void check_beat(lcdsc_pkg::rsp_beat_type got);
         lcdsc_pkg::rsp_beat_type want;
         if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual 0x%0h", $time, got);
         end else begin
            want = pending_beats.pop_front();
            beats_checked++;
            compare_field("segment_lines", want.segment_lines, got.segment_lines);
            compare_field("com_select", want.com_select, got.com_select);
            compare_field("com_level", want.com_level, got.com_level);
            compare_field("half_second", want.half_second, got.half_second);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we    = 1'b0;
   logic [7:0] csr_wdata = '0;

   lcdsc_req_if req_ch ();
   lcdsc_rsp_if rsp_ch ();

   scan_scoreboard sb;
   int unsigned    req_idle_pct     = 0;
   int unsigned    rsp_stall_pct    = 0;
   int unsigned    rsp_hold_request = 0;
   int unsigned    quiet_cycles     = 0;
   int unsigned    items_sent       = 0;
   int unsigned    reloads_written  = 0;

   lcd_quarter_duty_half_bias_scanner_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Observe both channels on the edge and count cycles with no beat moving.
   always @(posedge clock) begin : observe
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.kind, req_ch.slot, req_ch.value);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_beat({rsp_ch.segment_lines, rsp_ch.com_select, rsp_ch.com_level,
                           rsp_ch.half_second});
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Give up when the channels stop moving for too long.
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   // Result-side ready: random stalls, plus a long hold-off on request.
   initial begin : rsp_drive
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offers one request beat, with random idle cycles first, and returns when it is taken.
   task automatic send_item(logic [1:0] kind, logic [1:0] slot, logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.slot  <= slot;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Mostly ticks, with digit, flag and extra-byte writes mixed in.
   task automatic send_random_item();
      int unsigned roll;
      logic [1:0]  kind;
      logic [7:0]  value;
      roll  = $urandom_range(99);
      value = 8'($urandom_range(255));
      if (roll < 60) begin
         kind = lcdsc_pkg::KIND_TICK;
      end else if (roll < 78) begin
         kind = lcdsc_pkg::KIND_DIGIT;
         if ($urandom_range(3) != 0) value = 8'($urandom_range(17));
      end else if (roll < 89) begin
         kind = lcdsc_pkg::KIND_FLAGS;
      end else begin
         kind = lcdsc_pkg::KIND_EXTRA;
      end
      send_item(kind, 2'($urandom_range(3)), value);
   endtask

   // Stops offering, waits for every expected beat, then lets the block settle.
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      // Let the observer record the beat accepted at the edge just passed.
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reload(logic [7:0] ticks);
      drain_and_settle();
      csr_we    <= 1'b1;
      csr_wdata <= ticks;
      sb.set_reload(ticks);
      reloads_written++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] reload_plan [6];
      sb = new();
      reload_plan = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd7, 8'd125};
      reload_plan[5] = 8'($urandom_range(1, 255));
      req_ch.valid <= 1'b0;
      req_ch.kind  <= lcdsc_pkg::KIND_TICK;
      req_ch.slot  <= '0;
      req_ch.value <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lowest and highest digits, both blank forms, flag mask with
      // upper bits set, all-ones extra byte, then a full scan of each frame.
      send_item(lcdsc_pkg::KIND_DIGIT, 2'd0, 8'd0);
      send_item(lcdsc_pkg::KIND_DIGIT, 2'd1, 8'd15);
      send_item(lcdsc_pkg::KIND_DIGIT, 2'd2, 8'd16);
      send_item(lcdsc_pkg::KIND_DIGIT, 2'd3, 8'd255);
      send_item(lcdsc_pkg::KIND_FLAGS, 2'd3, 8'hF5);
      send_item(lcdsc_pkg::KIND_EXTRA, 2'd2, 8'hFF);
      repeat (8) send_item(lcdsc_pkg::KIND_TICK, 2'd0, 8'd0);
      send_item(lcdsc_pkg::KIND_DIGIT, 2'd0, 8'd8);
      send_item(lcdsc_pkg::KIND_FLAGS, 2'd0, 8'h0A);
      send_item(lcdsc_pkg::KIND_EXTRA, 2'd1, 8'h00);
      repeat (8) send_item(lcdsc_pkg::KIND_TICK, 2'd3, 8'hFF);

      // Hold the result side off for a long stretch while ticks keep coming.
      rsp_hold_request = LONG_HOLD;
      repeat (40) send_item(lcdsc_pkg::KIND_TICK, 2'($urandom_range(3)),
                            8'($urandom_range(255)));

      // Random phases, each with its own reload setting and one of four idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         write_reload(reload_plan[ph]);
         case (ph % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 87; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 87; end
            default: begin req_idle_pct = 15; rsp_stall_pct = 15; end
         endcase
         repeat (PHASE_ITEMS) send_random_item();
      end

      drain_and_settle();
      $display("summary: %0d request beats, %0d result beats checked, %0d half-second pulses",
               items_sent, sb.beats_checked, sb.pulses_seen);
      $display("summary: %0d reload settings, %0d mismatches", reloads_written, sb.errors);
      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ lcd_quarter_duty_half_bias_scanner_top.f @@
+incdir+hdl
hdl/lcdsc_pkg.sv
hdl/lcdsc_req_if.sv
hdl/lcdsc_rsp_if.sv
hdl/lcdsc_core.sv
hdl/lcdsc_out_reg.sv
hdl/lcd_quarter_duty_half_bias_scanner_top.sv
sim/tb.sv
